>>> src/sha1e_pkg.sv
package sha1e_pkg;

  localparam logic [1:0] OP_ABSORB = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_STATE    = 2'd2;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned Rounds     = 80;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1e_vars_t;

endpackage

>>> src/sha1e_ram.sv
module sha1e_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/sha1e_round.sv
module sha1e_round
  import sha1e_pkg::*;
(
  input  sha1e_vars_t vars_i,
  input  logic [31:0] w_i,
  input  logic [6:0]  round_i,
  output sha1e_vars_t vars_o
);

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (round_i < 7'd20) begin
      f = (vars_i.b & vars_i.c) | (~vars_i.b & vars_i.d);
      k = K0;
    end else if (round_i < 7'd40) begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = K1;
    end else if (round_i < 7'd60) begin
      f = (vars_i.b & vars_i.c) | (vars_i.b & vars_i.d) | (vars_i.c & vars_i.d);
      k = K2;
    end else begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = K3;
    end
    vars_o.a = {vars_i.a[26:0], vars_i.a[31:27]} + f + vars_i.e + w_i + k;
    vars_o.b = vars_i.a;
    vars_o.c = {vars_i.b[1:0], vars_i.b[31:2]};
    vars_o.d = vars_i.c;
    vars_o.e = vars_i.d;
  end

endmodule

>>> src/sha1_hash_engine_top.sv
// Byte-stream SHA-1 hasher.
// Input beats carry an opcode and a data byte: absorb, finish or start.
// Output beats carry one digest word with its index, a status and a last flag.
// An absorb or start beat leaves the input unstalled, but the 64th byte of a
// block starts a compression that keeps the input stalled while the block is
// loaded from the word memory, the rounds run one per cycle, and the result is
// added into the chaining words.
// A finish beat compresses one or two padded blocks and then presents five
// output beats, one per cycle while the receiver does not stall.
// A repeated finish presents the same five beats at once, and a finish in error
// presents a single status beat.
// While the receiver stalls, the current output beat holds and the input stays
// stalled; the next item is taken after the last beat is delivered.
// Reset loads the initial chaining words and clears the count and the flags.
module sha1_hash_engine_top
  import sha1e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [1:0] M_NORM = 2'd0;
  localparam logic [1:0] M_PAD1 = 2'd1;
  localparam logic [1:0] M_PAD2 = 2'd2;

  logic [2:0]  state_q;
  logic [1:0]  mode_q;
  logic [6:0]  cnt_q;
  logic [5:0]  fill_q;
  logic [23:0] acc_q;
  logic [63:0] bc_q;
  logic        fin_q;
  logic [1:0]  err_q;
  logic [31:0] chain_q [5];
  sha1e_vars_t vars_q;
  sha1e_vars_t vars_next;
  logic [31:0] w_q [BlockWords];
  logic [2:0]  oidx_q;
  logic        oerr_q;

  logic [31:0] ram_rdata;
  logic        ram_we;
  logic [31:0] ram_wdata;
  logic [3:0]  ld_idx;
  logic [3:0]  fpos;
  logic [31:0] partial;
  logic [31:0] ld_word;
  logic [31:0] w_new;
  logic [63:0] bc_inc;
  logic        accept;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign ram_we    = accept && (opcode_i == OP_ABSORB) && !fin_q && (err_q == ST_OK) &&
                     (fill_q[1:0] == 2'd3);
  assign ram_wdata = {acc_q, data_byte_i};
  assign bc_inc    = bc_q + 64'd8;

  sha1e_ram #(
    .WIDTH(32),
    .DEPTH(BlockWords)
  ) u_block_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q[5:2]),
    .wdata_i(ram_wdata),
    .raddr_i(cnt_q[3:0]),
    .rdata_o(ram_rdata)
  );

  sha1e_round u_round (
    .vars_i (vars_q),
    .w_i    (w_q[0]),
    .round_i(cnt_q),
    .vars_o (vars_next)
  );

  assign ld_idx = cnt_q[3:0] - 4'd1;
  assign fpos   = fill_q[5:2];

  always_comb begin
    case (fill_q[1:0])
      2'd0:    partial = {PAD_BYTE, 24'h0};
      2'd1:    partial = {acc_q[7:0], PAD_BYTE, 16'h0};
      2'd2:    partial = {acc_q[15:0], PAD_BYTE, 8'h0};
      default: partial = {acc_q[23:0], PAD_BYTE};
    endcase
  end

  always_comb begin
    ld_word = 32'h0;
    if (mode_q == M_NORM) begin
      ld_word = ram_rdata;
    end else if (mode_q == M_PAD1) begin
      if (ld_idx < fpos) begin
        ld_word = ram_rdata;
      end else if (ld_idx == fpos) begin
        ld_word = partial;
      end else if (fill_q < 6'd56 && ld_idx == 4'd14) begin
        ld_word = bc_q[63:32];
      end else if (fill_q < 6'd56 && ld_idx == 4'd15) begin
        ld_word = bc_q[31:0];
      end
    end else begin
      if (ld_idx == 4'd14) begin
        ld_word = bc_q[63:32];
      end else if (ld_idx == 4'd15) begin
        ld_word = bc_q[31:0];
      end
    end
  end

  logic [31:0] w_mix;
  assign w_mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= M_NORM;
      cnt_q      <= 7'd0;
      fill_q     <= 6'd0;
      acc_q      <= 24'h0;
      bc_q       <= 64'd0;
      fin_q      <= 1'b0;
      err_q      <= ST_OK;
      chain_q[0] <= IV0;
      chain_q[1] <= IV1;
      chain_q[2] <= IV2;
      chain_q[3] <= IV3;
      chain_q[4] <= IV4;
      oidx_q     <= 3'd0;
      oerr_q     <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (opcode_i == OP_START) begin
              chain_q[0] <= IV0;
              chain_q[1] <= IV1;
              chain_q[2] <= IV2;
              chain_q[3] <= IV3;
              chain_q[4] <= IV4;
              fill_q     <= 6'd0;
              bc_q       <= 64'd0;
              fin_q      <= 1'b0;
              err_q      <= ST_OK;
            end else if (opcode_i == OP_ABSORB) begin
              if (fin_q) begin
                err_q <= ST_STATE;
              end else if (err_q == ST_OK) begin
                acc_q  <= {acc_q[15:0], data_byte_i};
                fill_q <= fill_q + 6'd1;
                bc_q   <= bc_inc;
                if (bc_inc == 64'd0) begin
                  err_q <= ST_OVERFLOW;
                end
                if (fill_q == 6'd63) begin
                  state_q <= S_LOAD;
                  mode_q  <= M_NORM;
                  cnt_q   <= 7'd0;
                end
              end
            end else if (opcode_i == OP_FINISH) begin
              oidx_q <= 3'd0;
              if (err_q != ST_OK) begin
                oerr_q  <= 1'b1;
                state_q <= S_OUT;
              end else if (fin_q) begin
                oerr_q  <= 1'b0;
                state_q <= S_OUT;
              end else begin
                oerr_q  <= 1'b0;
                state_q <= S_LOAD;
                mode_q  <= M_PAD1;
                cnt_q   <= 7'd0;
              end
            end
          end
        end
        S_LOAD: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'd16) begin
            state_q <= S_ROUND;
            cnt_q   <= 7'd0;
            vars_q  <= '{chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
          end
        end
        S_ROUND: begin
          vars_q <= vars_next;
          cnt_q  <= cnt_q + 7'd1;
          if (cnt_q == 7'(Rounds - 1)) begin
            state_q <= S_ADD;
          end
        end
        S_ADD: begin
          chain_q[0] <= chain_q[0] + vars_q.a;
          chain_q[1] <= chain_q[1] + vars_q.b;
          chain_q[2] <= chain_q[2] + vars_q.c;
          chain_q[3] <= chain_q[3] + vars_q.d;
          chain_q[4] <= chain_q[4] + vars_q.e;
          if (mode_q == M_NORM) begin
            state_q <= S_IDLE;
          end else if (mode_q == M_PAD1 && fill_q >= 6'd56) begin
            state_q <= S_LOAD;
            mode_q  <= M_PAD2;
            cnt_q   <= 7'd0;
          end else begin
            fin_q   <= 1'b1;
            bc_q    <= 64'd0;
            fill_q  <= 6'd0;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            if (oerr_q || oidx_q == 3'd4) begin
              state_q <= S_IDLE;
            end else begin
              oidx_q <= oidx_q + 3'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_LOAD && cnt_q != 7'd0) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BlockWords-1] <= ld_word;
    end else if (state_q == S_ROUND) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[BlockWords-1] <= w_new;
    end
  end

  assign out_valid_o   = (state_q == S_OUT);
  assign digest_word_o = oerr_q ? 32'h0 : chain_q[oidx_q];
  assign word_index_o  = oerr_q ? 3'd0 : oidx_q;
  assign status_o      = oerr_q ? err_q : ST_OK;
  assign last_o        = oerr_q || (oidx_q == 3'd4);

endmodule
